// ----- sv/lsdt_pkg.sv -----
// lsdt_pkg: shared constants, types and codes for the lru stack distance tracker
// used by lsdt_cell, lsdt_chain and lru_stack_distance_tracker; no dependencies

package lsdt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int PAGE_BITS   = 32;

    localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CAP_W   = 7;
    localparam int DEPTH_W = 6;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef logic [PAGE_BITS-1:0] page_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic valid;
        logic shift_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic             evict;
        logic [IDX_W-1:0] depth;
    } chain_res_t;

endpackage

// ----- sv/lsdt_cell.sv -----
// lsdt_cell: one stack position holding a page number and its registered match flag
// depends on lsdt_pkg

module lsdt_cell (
    input  logic                 aclk,
    input  lsdt_pkg::cell_ctrl_t ctrl,
    input  lsdt_pkg::page_t      cmp_page,
    input  lsdt_pkg::page_t      prev_page,
    output lsdt_pkg::page_t      page_out,
    output logic                 match_out
);

    lsdt_pkg::page_t page_reg;
    logic            match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            match_reg <= ctrl.valid && (page_reg == cmp_page);
        end
        if (ctrl.shift_en) begin
            page_reg <= prev_page;
        end
    end

    assign page_out  = page_reg;
    assign match_out = match_reg;

endmodule

// ----- sv/lsdt_chain.sv -----
// lsdt_chain: row of lsdt_cell stack positions, hit and depth encoding, shift control
// depends on lsdt_pkg and lsdt_cell

module lsdt_chain (
    input  logic                          aclk,
    input  logic                          cmp_en,
    input  lsdt_pkg::page_t               cmp_page,
    input  logic                          upd_en,
    input  lsdt_pkg::page_t               new_page,
    input  logic [lsdt_pkg::OCC_W-1:0]    occ,
    input  logic [lsdt_pkg::OCC_W-1:0]    cap_eff,
    output lsdt_pkg::chain_res_t          res
);

    lsdt_pkg::page_t                      pages [lsdt_pkg::MAX_ENTRIES];
    logic [lsdt_pkg::MAX_ENTRIES-1:0]     match;
    lsdt_pkg::cell_ctrl_t                 ctrl  [lsdt_pkg::MAX_ENTRIES];
    logic [lsdt_pkg::OCC_W-1:0]           limit;
    logic [lsdt_pkg::IDX_W-1:0]           depth;
    logic                                 hit;
    logic                                 evict;

    always_comb begin
        depth = '0;
        for (int i = 0; i < lsdt_pkg::MAX_ENTRIES; i++) begin
            depth = depth | (match[i] ? lsdt_pkg::IDX_W'(i) : '0);
        end
    end

    assign hit   = |match;
    assign evict = !hit && (occ >= cap_eff);

    always_comb begin
        if (hit) begin
            limit = lsdt_pkg::OCC_W'(depth);
        end else if (evict) begin
            limit = occ - lsdt_pkg::OCC_W'(1);
        end else begin
            limit = occ;
        end
    end

    genvar g;
    generate
        for (g = 0; g < lsdt_pkg::MAX_ENTRIES; g++) begin : g_cell
            lsdt_pkg::page_t prev;

            if (g == 0) begin : g_head
                assign prev = new_page;
            end else begin : g_body
                assign prev = pages[g-1];
            end

            assign ctrl[g].cmp_en   = cmp_en;
            assign ctrl[g].valid    = lsdt_pkg::OCC_W'(g) < occ;
            assign ctrl[g].shift_en = upd_en && (lsdt_pkg::OCC_W'(g) <= limit);

            lsdt_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[g]),
                .cmp_page  (cmp_page),
                .prev_page (prev),
                .page_out  (pages[g]),
                .match_out (match[g])
            );
        end
    endgenerate

    assign res.hit   = hit;
    assign res.evict = evict;
    assign res.depth = depth;

endmodule

// ----- sv/lru_stack_distance_tracker.sv -----
// lru_stack_distance_tracker: top level with stream ports, capacity register,
// control sequencer and output register; depends on lsdt_pkg and lsdt_chain
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata[31:0] page_number
// m_        out  m_tvalid/m_tready  m_tdata[7:0]  hit, stack_depth, evicted
// apb       in   psel/penable       capacity at address 0
//
// each transaction has a compare step, in which every stack cell is compared in parallel,
// and an update step that shifts the cell row and registers the result
// the output register holds a result while the next transaction is compared
// a stalled m_ side holds the update cycle until the register frees
// reset empties the stack at once (occupancy to zero) and sets capacity to 64

module lru_stack_distance_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsdt_pkg::IN_W-1:0]     s_tdata,   // [31:0] page_number

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsdt_pkg::OUT_W-1:0]    m_tdata,   // [0] hit, [6:1] stack_depth, [7] evicted

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsdt_pkg::ADDR_W-1:0]   paddr,
    input  logic [lsdt_pkg::DATA_W-1:0]   pwdata,
    output logic [lsdt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    lsdt_pkg::state_t                     state_reg, state_next;
    logic [lsdt_pkg::CAP_W-1:0]           capacity_reg;
    logic [lsdt_pkg::OCC_W-1:0]           occ_reg, occ_next;
    logic [lsdt_pkg::OCC_W-1:0]           cap_eff;
    lsdt_pkg::page_t                      page_reg;
    logic                                 out_valid_reg;
    logic [lsdt_pkg::OUT_W-1:0]           out_data_reg;
    lsdt_pkg::chain_res_t                 res;
    lsdt_pkg::page_t                      in_page;
    logic                                 accept;
    logic                                 exec_go;
    logic                                 cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == lsdt_pkg::REG_CAPACITY) ?
                      lsdt_pkg::DATA_W'(capacity_reg) : '0;

    assign in_page  = lsdt_pkg::PAGE_BITS'(s_tdata);
    assign s_tready = (state_reg == lsdt_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == lsdt_pkg::ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = lsdt_pkg::OCC_W'(1);
        end else if (int'(capacity_reg) > lsdt_pkg::MAX_ENTRIES) begin
            cap_eff = lsdt_pkg::OCC_W'(lsdt_pkg::MAX_ENTRIES);
        end else begin
            cap_eff = lsdt_pkg::OCC_W'(capacity_reg);
        end
    end

    lsdt_chain u_chain (
        .aclk     (aclk),
        .cmp_en   (accept),
        .cmp_page (in_page),
        .upd_en   (exec_go),
        .new_page (page_reg),
        .occ      (occ_reg),
        .cap_eff  (cap_eff),
        .res      (res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsdt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = lsdt_pkg::ST_EXEC;
                end
            end
            lsdt_pkg::ST_EXEC: begin
                if (exec_go) begin
                    state_next = lsdt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        occ_next = occ_reg;
        if (exec_go && !res.hit && !res.evict) begin
            occ_next = occ_reg + lsdt_pkg::OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lsdt_pkg::ST_IDLE;
            occ_reg       <= '0;
            capacity_reg  <= lsdt_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_wr && (paddr[2] == lsdt_pkg::REG_CAPACITY)) begin
                capacity_reg <= pwdata[lsdt_pkg::CAP_W-1:0];
            end
            if (exec_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg <= in_page;
        end
        if (exec_go) begin
            out_data_reg <= {res.evict, lsdt_pkg::DEPTH_W'(res.hit ? res.depth : '0), res.hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(occ_reg) <= lsdt_pkg::MAX_ENTRIES)
        else $error("occupancy beyond stack size");

    a_hit_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && res.hit) |-> (lsdt_pkg::OCC_W'(res.depth) < occ_reg))
        else $error("hit outside occupied cells");

    a_occ_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && !res.hit && !res.evict) |=>
            (occ_reg == $past(occ_reg) + lsdt_pkg::OCC_W'(1)))
        else $error("occupancy not grown on plain miss");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg[0] && out_data_reg[7]))
        else $error("eviction flagged on a hit");
`endif

endmodule

// ----- bench/lsdt_checker.sv -----
`timescale 1ns / 100ps
// lsdt_checker: watches the stream and apb ports of the lru stack distance tracker,
// predicts each result from its own copy of the recency stack and compares
// depends on lsdt_pkg

module lsdt_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [lsdt_pkg::IN_W-1:0]   s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [lsdt_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lsdt_pkg::ADDR_W-1:0] paddr,
    input  logic [lsdt_pkg::DATA_W-1:0] pwdata,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic                         evicted;
        logic [lsdt_pkg::DEPTH_W-1:0] depth;
        logic                         hit;
    } access_res_t;

    lsdt_pkg::page_t            lru_pages [lsdt_pkg::MAX_ENTRIES];
    int                         lru_fill;
    logic [lsdt_pkg::CAP_W-1:0] cap_reg;
    access_res_t                expected_q [$];
    access_res_t                exp_res;
    access_res_t                got_res;

    function automatic access_res_t lookup_and_update(input lsdt_pkg::page_t pg);
        access_res_t res;
        int          cap;
        int          pos;
        int          i;
        logic        found;
        if (cap_reg == '0)
            cap = 1;
        else if (int'(cap_reg) > lsdt_pkg::MAX_ENTRIES)
            cap = lsdt_pkg::MAX_ENTRIES;
        else
            cap = int'(cap_reg);
        found = 1'b0;
        pos   = 0;
        for (i = 0; i < lru_fill; i++) begin
            if (!found && lru_pages[i] == pg) begin
                found = 1'b1;
                pos   = i;
            end
        end
        res = '0;
        if (found) begin
            for (i = pos; i > 0; i--)
                lru_pages[i] = lru_pages[i-1];
            res.hit   = 1'b1;
            res.depth = lsdt_pkg::DEPTH_W'(pos);
        end else if (lru_fill >= cap) begin
            // full: deepest entry falls off, fill level unchanged
            for (i = lru_fill - 1; i > 0; i--)
                lru_pages[i] = lru_pages[i-1];
            res.evicted = 1'b1;
        end else begin
            for (i = lru_fill; i > 0; i--)
                lru_pages[i] = lru_pages[i-1];
            lru_fill++;
        end
        lru_pages[0] = pg;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lru_fill   = 0;
            cap_reg    = lsdt_pkg::CAPACITY_RESET;
            fail_count = 0;
            expected_q.delete();
            pending   <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == lsdt_pkg::REG_CAPACITY)
                cap_reg = pwdata[lsdt_pkg::CAP_W-1:0];
            if (s_tvalid && s_tready)
                expected_q.push_back(lookup_and_update(lsdt_pkg::PAGE_BITS'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got_res = access_res_t'(m_tdata);
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result 0x%02h", m_tdata));
                end else begin
                    exp_res = expected_q.pop_front();
                    if (got_res.hit !== exp_res.hit)
                        report_mismatch($sformatf("hit %b, expected %b",
                                                  got_res.hit, exp_res.hit));
                    if (got_res.depth !== exp_res.depth)
                        report_mismatch($sformatf("stack_depth %0d, expected %0d",
                                                  got_res.depth, exp_res.depth));
                    if (got_res.evicted !== exp_res.evicted)
                        report_mismatch($sformatf("evicted %b, expected %b",
                                                  got_res.evicted, exp_res.evicted));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: stimulus for the lru stack distance tracker, directed accesses then
// random working-set traffic over several capacity settings with random stalls
// depends on lsdt_pkg, lru_stack_distance_tracker and lsdt_checker

module tb_top;

    localparam int POOL_SIZE = 96;

    localparam lsdt_pkg::page_t FIRST_PAGES [13] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
        32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
        32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001
    };

    localparam int PHASE_CAPS [8] = '{1, 2, 127, 48, 64, 5, 100, 33};

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [lsdt_pkg::IN_W-1:0]   s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [lsdt_pkg::OUT_W-1:0]  m_tdata;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lsdt_pkg::ADDR_W-1:0] paddr;
    logic [lsdt_pkg::DATA_W-1:0] pwdata;
    logic [lsdt_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    int              fail_count;
    int              pending;
    bit              press_go;
    bit              press_done;
    int              calm_left;
    lsdt_pkg::page_t page_pool [POOL_SIZE];

    lru_stack_distance_tracker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lsdt_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL lru_stack_distance_tracker");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int eff_capacity(input int cap);
        if (cap == 0)
            return 1;
        else if (cap > lsdt_pkg::MAX_ENTRIES)
            return lsdt_pkg::MAX_ENTRIES;
        else
            return cap;
    endfunction

    task automatic send_page(input lsdt_pkg::page_t pg);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= pg;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(30, 80);
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lsdt_pkg::CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lsdt_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= lsdt_pkg::DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int ws);
        int              k;
        int              r;
        lsdt_pkg::page_t pg;
        for (k = 0; k < ws; k++)
            page_pool[k] = $urandom();
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                pg = page_pool[$urandom_range(0, ws - 1)];
            end else if (r < 88) begin
                // near miss: one bit away from a working-set page
                pg = page_pool[$urandom_range(0, ws - 1)] ^
                     (lsdt_pkg::page_t'(1) << $urandom_range(0, 31));
            end else if (r < 91) begin
                page_pool[$urandom_range(0, ws - 1)] = $urandom();
                pg = page_pool[$urandom_range(0, ws - 1)];
            end else begin
                pg = $urandom();
            end
            send_page(pg);
        end
    endtask

    initial begin
        int              ph;
        int              k;
        int              cap_val;
        int              ws_max;
        lsdt_pkg::page_t base;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        calm_left  = 0;
        press_go   = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (FIRST_PAGES[i])
            send_page(FIRST_PAGES[i]);

        // capacity zero behaves as one, stack stays deeper than capacity
        drain();
        write_capacity(lsdt_pkg::CAP_W'(0));
        send_page(32'h1234_5678);
        send_page(32'h1234_5678);
        send_page(32'hFFFF_FFFF);

        for (ph = 0; ph < 10; ph++) begin
            drain();
            cap_val = (ph < 8) ? PHASE_CAPS[ph] : $urandom_range(0, 127);
            write_capacity(lsdt_pkg::CAP_W'(cap_val));
            if (ph == 4) begin
                // fill a full stack, hit the deepest entry, then force an eviction
                base = $urandom();
                for (k = 0; k < lsdt_pkg::MAX_ENTRIES; k++)
                    send_page(base + lsdt_pkg::page_t'(k));
                send_page(base);
                send_page(base + lsdt_pkg::page_t'(lsdt_pkg::MAX_ENTRIES));
            end
            if (ph == 5)
                press_go = 1'b1;
            ws_max = eff_capacity(cap_val) + eff_capacity(cap_val) / 2 + 3;
            if (ws_max > POOL_SIZE)
                ws_max = POOL_SIZE;
            run_phase(170, $urandom_range(1, ws_max));
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("PASS lru_stack_distance_tracker");
        else
            $display("FAIL lru_stack_distance_tracker");
        $finish;
    end

    initial begin
        int stall;
        int run;
        press_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (press_go && !press_done) begin
                // long hold-off so the block fills and backs up the input
                press_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
        end
    end

endmodule
